/* hdl/assert_macros.svh */
// shared assertion macros, sampled on clk_i and disabled while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define MCLS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mcls assertion failed");

// next-cycle implication
`define MCLS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mcls assertion failed");

`endif

/* hdl/mcls_pkg.sv */
package mcls_pkg;

  localparam int unsigned SAMPLE_W   = 12;
  localparam int unsigned DRIVE_W    = 7;
  localparam int unsigned MEAN_W     = 12;
  localparam int unsigned LIMIT_W    = 11;
  localparam int unsigned ZERO_W     = 12;
  localparam int unsigned OFFSET_W   = 8;
  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [LIMIT_W-1:0]  LIMIT_RST  = 11'd1282;
  localparam logic [ZERO_W-1:0]   ZERO_RST   = 12'd1935;
  localparam logic [OFFSET_W-1:0] OFFSET_RST = 8'd74;

  typedef enum logic [1:0] {
    REG_CURRENT_LIMIT  = 2'd0,
    REG_ZERO_POINT     = 2'd1,
    REG_REVERSE_OFFSET = 2'd2
  } reg_idx_e;

  // one slot of the sample window
  typedef struct packed {
    logic                filled;
    logic [SAMPLE_W-1:0] sample;
  } cell_t;

endpackage

/* hdl/mcls_stream_if.sv */
interface mcls_in_if;
  import mcls_pkg::*;
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] current_sample;
  logic [DRIVE_W-1:0]  drive_in;

  modport source (output valid, current_sample, drive_in, input ready);
  modport sink (input valid, current_sample, drive_in, output ready);
endinterface

interface mcls_out_if;
  import mcls_pkg::*;
  logic               valid;
  logic               ready;
  logic [MEAN_W-1:0]  mean_current;
  logic [DRIVE_W-1:0] drive_out;
  logic               drive_changed;
  logic               motor_stop;

  modport source (output valid, mean_current, drive_out, drive_changed, motor_stop,
                  input ready);
  modport sink (input valid, mean_current, drive_out, drive_changed, motor_stop,
                output ready);
endinterface

/* hdl/mcls_cell.sv */
module mcls_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            shift_i,
  input  mcls_pkg::cell_t cell_i,
  output mcls_pkg::cell_t cell_o
);
  import mcls_pkg::*;

  logic                filled_q;
  logic [SAMPLE_W-1:0] sample_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filled_q <= 1'b0;
    end else if (shift_i) begin
      filled_q <= cell_i.filled;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      sample_q <= cell_i.sample;
    end
  end

  assign cell_o.filled = filled_q;
  assign cell_o.sample = sample_q;

endmodule

/* hdl/mcls_divide.sv */
module mcls_divide #(
  parameter int unsigned SUM_W   = 19,
  parameter int unsigned DIVISOR = 100
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [SUM_W-1:0]             sum_i,
  input  logic [mcls_pkg::DRIVE_W-1:0] drive_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [mcls_pkg::MEAN_W-1:0]  mean_o,
  output logic [mcls_pkg::DRIVE_W-1:0] drive_o
);
  import mcls_pkg::*;

  // floor(2^SUM_W / DIVISOR) undershoots the quotient by at most one
  localparam longint unsigned RECIP_L = (64'd1 << SUM_W) / DIVISOR;
  localparam logic [SUM_W-1:0] RECIP  = SUM_W'(RECIP_L);
  localparam int unsigned REM_W       = $clog2(2 * DIVISOR);
  localparam logic [REM_W-1:0] DIV_R  = REM_W'(DIVISOR);
  localparam logic [SUM_W-1:0] DIV_S  = SUM_W'(DIVISOR);

  logic                 a_valid_q, b_valid_q, c_valid_q;
  logic                 rdy_a, rdy_b, rdy_c;
  logic [2*SUM_W-1:0]   a_prod_q;
  logic [SUM_W-1:0]     a_sum_q;
  logic [DRIVE_W-1:0]   a_drive_q, b_drive_q, c_drive_q;
  logic [MEAN_W-1:0]    b_quot_q, c_mean_q;
  logic [REM_W-1:0]     b_rem_q;
  logic [MEAN_W-1:0]    quot_est;
  logic [SUM_W-1:0]     back_prod;
  logic [REM_W-1:0]     rem_est;
  logic [MEAN_W-1:0]    mean_fix;

  assign rdy_c = !c_valid_q || out_ready_i;
  assign rdy_b = !b_valid_q || rdy_c;
  assign rdy_a = !a_valid_q || rdy_b;
  assign in_ready_o = rdy_a;

  assign quot_est  = a_prod_q[SUM_W +: MEAN_W];
  assign back_prod = SUM_W'(SUM_W'(quot_est) * DIV_S);
  assign rem_est   = REM_W'(a_sum_q - back_prod);
  assign mean_fix  = b_quot_q + MEAN_W'(b_rem_q >= DIV_R);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else begin
      if (rdy_a) begin
        a_valid_q <= in_valid_i;
      end
      if (rdy_b) begin
        b_valid_q <= a_valid_q;
      end
      if (rdy_c) begin
        c_valid_q <= b_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_a && in_valid_i) begin
      a_prod_q  <= (2*SUM_W)'(sum_i) * (2*SUM_W)'(RECIP);
      a_sum_q   <= sum_i;
      a_drive_q <= drive_i;
    end
    if (rdy_b && a_valid_q) begin
      b_quot_q  <= quot_est;
      b_rem_q   <= rem_est;
      b_drive_q <= a_drive_q;
    end
    if (rdy_c && b_valid_q) begin
      c_mean_q  <= mean_fix;
      c_drive_q <= b_drive_q;
    end
  end

  assign out_valid_o = c_valid_q;
  assign mean_o      = c_mean_q;
  assign drive_o     = c_drive_q;

endmodule

/* hdl/motor_current_limit_stepper.sv */
// channel    | direction | transaction carries
// sample_i   | in        | current_sample, drive_in
// result_o   | out       | mean_current, drive_out, drive_changed, motor_stop
// apb (p*)   | in/out    | current_limit, zero_point, reverse_offset
//
// one sample transaction per cycle is taken sustained while result_o is not stalled; a result
// is valid once its sample has passed the sum stage (loaded at the accepting edge), the three
// divide stages and the limit step
// the sample window is a chain of WINDOW_LENGTH cells shifting once per sample
// a result is produced only once the chain has filled; reset empties it at once
// a stalled result_o backs up through the stages until sample_i.ready drops
module motor_current_limit_stepper #(
  parameter int unsigned WINDOW_LENGTH = 100,
  parameter int unsigned NEUTRAL_DUTY  = 50
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  mcls_in_if.sink                         sample_i,
  mcls_out_if.source                      result_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mcls_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [mcls_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [mcls_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);
  import mcls_pkg::*;

  localparam int unsigned SUM_W = $clog2(((1 << SAMPLE_W) - 1) * WINDOW_LENGTH + 1);
  localparam logic [8:0] NEUTRAL = 9'(NEUTRAL_DUTY);

  // configuration
  logic [LIMIT_W-1:0]  limit_q;
  logic [ZERO_W-1:0]   zero_q;
  logic [OFFSET_W-1:0] offset_q;
  logic                cfg_wr;
  reg_idx_e            cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q  <= LIMIT_RST;
      zero_q   <= ZERO_RST;
      offset_q <= OFFSET_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_CURRENT_LIMIT:  limit_q  <= pwdata[LIMIT_W-1:0];
        REG_ZERO_POINT:     zero_q   <= pwdata[ZERO_W-1:0];
        REG_REVERSE_OFFSET: offset_q <= pwdata[OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_CURRENT_LIMIT:  prdata = CFG_DATA_W'(limit_q);
      REG_ZERO_POINT:     prdata = CFG_DATA_W'(zero_q);
      REG_REVERSE_OFFSET: prdata = CFG_DATA_W'(offset_q);
      default:            prdata = '0;
    endcase
  end

  // sample window as a cell chain
  cell_t               chain [WINDOW_LENGTH+1];
  logic                accept;
  logic                in_ready;
  logic                window_full;
  logic [SAMPLE_W-1:0] oldest;
  logic [SUM_W-1:0]    sum_q, sum_d;

  assign chain[0].filled = 1'b1;
  assign chain[0].sample = sample_i.current_sample;

  for (genvar i = 0; i < WINDOW_LENGTH; i++) begin : g_cell
    mcls_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (accept),
      .cell_i  (chain[i]),
      .cell_o  (chain[i+1])
    );
  end

  assign accept      = sample_i.valid && in_ready;
  // the sample now entering completes the window when the next-to-last cell is filled
  assign window_full = chain[WINDOW_LENGTH-1].filled;
  assign oldest      = chain[WINDOW_LENGTH].filled ? chain[WINDOW_LENGTH].sample : '0;
  assign sum_d       = sum_q - SUM_W'(oldest) + SUM_W'(sample_i.current_sample);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (accept) begin
      sum_q <= sum_d;
    end
  end

  // sum snapshot stage
  logic               s1_valid_q;
  logic [SUM_W-1:0]   s1_sum_q;
  logic [DRIVE_W-1:0] s1_drive_q;
  logic               div_in_ready;
  logic               div_valid;
  logic               step_ready;
  logic [MEAN_W-1:0]  div_mean;
  logic [DRIVE_W-1:0] div_drive;

  assign in_ready       = !s1_valid_q || div_in_ready;
  assign sample_i.ready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready) begin
      s1_valid_q <= accept && window_full;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_sum_q   <= sum_d;
      s1_drive_q <= sample_i.drive_in;
    end
  end

  mcls_divide #(
    .SUM_W   (SUM_W),
    .DIVISOR (WINDOW_LENGTH)
  ) u_divide (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s1_valid_q),
    .in_ready_o  (div_in_ready),
    .sum_i       (s1_sum_q),
    .drive_i     (s1_drive_q),
    .out_valid_o (div_valid),
    .out_ready_i (step_ready),
    .mean_o      (div_mean),
    .drive_o     (div_drive)
  );

  // limit step and output register
  logic [ZERO_W:0]     up_thr;
  logic signed [13:0]  rev_thr;
  logic [8:0]          drive_w, drive_inc, drive_dec;
  logic                step_up, step_down;
  logic [DRIVE_W-1:0]  new_drive;
  logic                changed, stop;
  logic                out_valid_q;
  logic [MEAN_W-1:0]   out_mean_q;
  logic [DRIVE_W-1:0]  out_drive_q;
  logic                out_changed_q, out_stop_q;

  assign up_thr    = {1'b0, zero_q} + (ZERO_W+1)'(limit_q);
  assign rev_thr   = $signed(14'(zero_q)) - $signed(14'(limit_q)) - $signed(14'(offset_q));
  assign drive_w   = 9'(div_drive);
  assign drive_inc = drive_w + 9'd1;
  assign drive_dec = drive_w - 9'd1;
  assign step_up   = ((ZERO_W+1)'(div_mean) > up_thr) && (drive_w < NEUTRAL);
  assign step_down = ($signed(14'(div_mean)) < rev_thr) && (drive_w > NEUTRAL);

  always_comb begin
    new_drive = div_drive;
    changed   = 1'b0;
    stop      = 1'b0;
    if (step_up) begin
      changed = 1'b1;
      if (drive_inc >= NEUTRAL) begin
        new_drive = NEUTRAL[DRIVE_W-1:0];
        stop      = 1'b1;
      end else begin
        new_drive = drive_inc[DRIVE_W-1:0];
      end
    end else if (step_down) begin
      changed = 1'b1;
      if (drive_dec <= NEUTRAL) begin
        new_drive = NEUTRAL[DRIVE_W-1:0];
        stop      = 1'b1;
      end else begin
        new_drive = drive_dec[DRIVE_W-1:0];
      end
    end
  end

  assign step_ready = !out_valid_q || result_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step_ready) begin
      out_valid_q <= div_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_ready && div_valid) begin
      out_mean_q    <= div_mean;
      out_drive_q   <= new_drive;
      out_changed_q <= changed;
      out_stop_q    <= stop;
    end
  end

  assign result_o.valid         = out_valid_q;
  assign result_o.mean_current  = out_mean_q;
  assign result_o.drive_out     = out_drive_q;
  assign result_o.drive_changed = out_changed_q;
  assign result_o.motor_stop    = out_stop_q;

endmodule

/* hdl/mcls_checker.sv */
`include "assert_macros.svh"

module mcls_checker #(
  parameter int unsigned NEUTRAL_DUTY = 50
) (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            out_valid_i,
  input logic                            out_ready_i,
  input logic [mcls_pkg::MEAN_W-1:0]     mean_i,
  input logic [mcls_pkg::DRIVE_W-1:0]    drive_out_i,
  input logic                            changed_i,
  input logic                            stop_i,
  input logic                            psel_i,
  input logic                            penable_i,
  input logic                            pwrite_i,
  input logic [mcls_pkg::CFG_ADDR_W-1:0] paddr_i,
  input logic [mcls_pkg::CFG_DATA_W-1:0] pwdata_i,
  input logic [mcls_pkg::CFG_DATA_W-1:0] prdata_i
);
  import mcls_pkg::*;

  localparam logic [DRIVE_W-1:0] NEUTRAL = DRIVE_W'(NEUTRAL_DUTY);

  logic limit_wr;
  assign limit_wr = psel_i && penable_i && pwrite_i && (paddr_i[3:2] == REG_CURRENT_LIMIT);

  // a held result keeps its payload
  `MCLS_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(mean_i) && $stable(drive_out_i) && $stable(changed_i) && $stable(stop_i))
  // a stop is always a step that lands on neutral
  `MCLS_ASSERT_SAME(a_stop_neutral, out_valid_i && stop_i, changed_i && (drive_out_i == NEUTRAL))
  // no stop without a step
  `MCLS_ASSERT_SAME(a_stop_needs_step, out_valid_i && !changed_i, !stop_i)
  // a written limit reads back on the next cycle
  `MCLS_ASSERT_NEXT(a_limit_readback, limit_wr, (paddr_i[3:2] != REG_CURRENT_LIMIT) || (prdata_i[LIMIT_W-1:0] == $past(pwdata_i[LIMIT_W-1:0])))

endmodule

bind motor_current_limit_stepper mcls_checker #(
  .NEUTRAL_DUTY (NEUTRAL_DUTY)
) u_mcls_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .mean_i      (result_o.mean_current),
  .drive_out_i (result_o.drive_out),
  .changed_i   (result_o.drive_changed),
  .stop_i      (result_o.motor_stop),
  .psel_i      (psel),
  .penable_i   (penable),
  .pwrite_i    (pwrite),
  .paddr_i     (paddr),
  .pwdata_i    (pwdata),
  .prdata_i    (prdata)
);

/* bench/motor_current_limit_stepper_test.sv */
module motor_current_limit_stepper_test;
  timeunit 1ns;
  timeprecision 1ps;
  import mcls_pkg::*;

  localparam int unsigned WINDOW        = 100;
  localparam int unsigned NEUTRAL       = 50;
  localparam int          SAMPLE_MAX    = (1 << SAMPLE_W) - 1;
  localparam int unsigned SLACK_CYCLES  = 16;
  localparam int unsigned IDLE_LIMIT    = 5000;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned REG_SPARE_IDX = 3;
  localparam int unsigned PHASE_ITEMS   = 150;
  localparam int unsigned REPORT_LIMIT  = 10;

  localparam logic [SAMPLE_W-1:0] EDGE_SAMPLES [8] = '{
    12'd0, 12'd4095, 12'hAAA, 12'h555, 12'd2047, 12'd2048, 12'd1, 12'd4094
  };
  localparam logic [DRIVE_W-1:0] EDGE_DRIVES [12] = '{
    7'd0, 7'd127, 7'd49, 7'd50, 7'd51, 7'd100, 7'd101, 7'd1, 7'd64, 7'd63, 7'd99, 7'd48
  };

  typedef enum int unsigned {LVL_ANY, LVL_HIGH, LVL_LOW, LVL_FWD_EDGE, LVL_REV_EDGE} level_e;
  typedef enum int unsigned {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_COMB} rx_mode_e;

  typedef struct packed {
    logic [MEAN_W-1:0]  mean_current;
    logic [DRIVE_W-1:0] drive_out;
    logic               drive_changed;
    logic               motor_stop;
  } duty_result_t;

  class duty_limit_board;
    logic [SAMPLE_W-1:0] ring [WINDOW];
    int unsigned slot;
    bit          full;
    int unsigned sum;
    int unsigned limit;
    int unsigned zero;
    int unsigned offset;
    duty_result_t expected_duty[$];
    int unsigned errors;

    function new();
      foreach (ring[i]) ring[i] = '0;
      slot   = 0;
      full   = 1'b0;
      sum    = 0;
      limit  = LIMIT_RST;
      zero   = ZERO_RST;
      offset = OFFSET_RST;
      errors = 0;
    endfunction

    function void complain(string msg);
      errors++;
      if (errors <= REPORT_LIMIT) $display("%s", msg);
    endfunction

    function void set_reg(int unsigned idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        REG_CURRENT_LIMIT:  limit  = value[LIMIT_W-1:0];
        REG_ZERO_POINT:     zero   = value[ZERO_W-1:0];
        REG_REVERSE_OFFSET: offset = value[OFFSET_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [CFG_DATA_W-1:0] reg_value(int unsigned idx);
      case (idx)
        REG_CURRENT_LIMIT:  return CFG_DATA_W'(limit);
        REG_ZERO_POINT:     return CFG_DATA_W'(zero);
        REG_REVERSE_OFFSET: return CFG_DATA_W'(offset);
        default:            return '0;
      endcase
    endfunction

    // store the sample, and once the window is full work out the limit step
    function void take_sample(logic [SAMPLE_W-1:0] sample, logic [DRIVE_W-1:0] drive);
      int unsigned  mean;
      int           rev_floor;
      int unsigned  stepped;
      duty_result_t r;
      sum = sum - ring[slot] + sample;
      ring[slot] = sample;
      if (slot == WINDOW - 1) begin
        slot = 0;
        full = 1'b1;
      end else begin
        slot++;
      end
      if (!full) return;
      mean = sum / WINDOW;
      rev_floor = int'(zero) - int'(limit) - int'(offset);
      r.mean_current  = mean[MEAN_W-1:0];
      r.drive_out     = drive;
      r.drive_changed = 1'b0;
      r.motor_stop    = 1'b0;
      if (mean > zero + limit && drive < NEUTRAL) begin
        stepped = drive + 1;
        r.drive_changed = 1'b1;
        if (stepped >= NEUTRAL) begin
          stepped = NEUTRAL;
          r.motor_stop = 1'b1;
        end
        r.drive_out = stepped[DRIVE_W-1:0];
      end else if (int'(mean) < rev_floor && drive > NEUTRAL) begin
        stepped = drive - 1;
        r.drive_changed = 1'b1;
        if (stepped <= NEUTRAL) begin
          stepped = NEUTRAL;
          r.motor_stop = 1'b1;
        end
        r.drive_out = stepped[DRIVE_W-1:0];
      end
      expected_duty.push_back(r);
    endfunction

    function void check_duty(logic [MEAN_W-1:0] mean_current, logic [DRIVE_W-1:0] drive_out,
                             logic drive_changed, logic motor_stop);
      duty_result_t want;
      if (expected_duty.size() == 0) begin
        complain($sformatf("unexpected result: mean %0d drive %0d changed %0b stop %0b",
                           mean_current, drive_out, drive_changed, motor_stop));
        return;
      end
      want = expected_duty.pop_front();
      if (mean_current !== want.mean_current || drive_out !== want.drive_out ||
          drive_changed !== want.drive_changed || motor_stop !== want.motor_stop) begin
        complain($sformatf({"result mismatch (got/expected): mean %0d/%0d drive %0d/%0d",
                            " changed %0b/%0b stop %0b/%0b"},
                           mean_current, want.mean_current, drive_out, want.drive_out,
                           drive_changed, want.drive_changed, motor_stop, want.motor_stop));
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic psel;
  logic penable;
  logic pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic pready;

  mcls_in_if  sample_bus ();
  mcls_out_if result_bus ();

  duty_limit_board board = new();
  bit hold_off_req = 1'b0;
  int unsigned idle_cycles = 0;

  motor_current_limit_stepper u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (sample_bus),
    .result_o (result_bus),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && result_bus.valid === 1'b1 && result_bus.ready === 1'b1) begin
      board.check_duty(result_bus.mean_current, result_bus.drive_out,
                       result_bus.drive_changed, result_bus.motor_stop);
    end
  end

  always @(posedge clk_i) begin
    if ((sample_bus.valid && sample_bus.ready) || (result_bus.valid && result_bus.ready) ||
        (psel && penable)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (idle_cycles >= IDLE_LIMIT);
    $display("motor_current_limit_stepper_test: done, errors");
    $finish;
  end

  // result side: stall modes that change every so often, plus one long hold-off
  initial begin : receiver
    rx_mode_e    mode;
    int unsigned left;
    int unsigned tick;
    result_bus.ready <= 1'b0;
    mode = RX_OPEN;
    left = 0;
    tick = 0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        result_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_off_req = 1'b0;
      end
      if (left == 0) begin
        mode = rx_mode_e'($urandom_range(0, 3));
        left = $urandom_range(40, 160);
      end
      left--;
      tick++;
      case (mode)
        RX_OPEN:  result_bus.ready <= 1'b1;
        RX_LIGHT: result_bus.ready <= ($urandom_range(0, 3) != 0);
        RX_HEAVY: result_bus.ready <= ($urandom_range(0, 9) < 3);
        default:  result_bus.ready <= (tick % 3 != 0);
      endcase
    end
  end

  task automatic send_item(input logic [SAMPLE_W-1:0] sample, input logic [DRIVE_W-1:0] drive);
    sample_bus.valid          <= 1'b1;
    sample_bus.current_sample <= sample;
    sample_bus.drive_in       <= drive;
    do @(posedge clk_i); while (sample_bus.ready !== 1'b1);
    board.take_sample(sample, drive);
  endtask

  task automatic wait_drained();
    while (board.expected_duty.size() != 0) @(posedge clk_i);
    // samples that make no result may still be in the pipe
    repeat (SLACK_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(input int unsigned idx, input logic [CFG_DATA_W-1:0] value,
                           input bit read_back);
    logic [CFG_DATA_W-1:0] want;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'(4 * idx);
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    board.set_reg(idx, value);
    if (!read_back) begin
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
    end else begin
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clk_i);
      penable <= 1'b1;
      do @(posedge clk_i); while (pready !== 1'b1);
      want = board.reg_value(idx);
      if (prdata !== want) begin
        board.complain($sformatf("register %0d read back %0h, expected %0h", idx, prdata, want));
      end
      psel    <= 1'b0;
      penable <= 1'b0;
    end
  endtask

  task automatic set_limits(input logic [CFG_DATA_W-1:0] limit, input logic [CFG_DATA_W-1:0] zero,
                            input logic [CFG_DATA_W-1:0] offset);
    wait_drained();
    cfg_write(REG_CURRENT_LIMIT, limit, 1'b1);
    cfg_write(REG_ZERO_POINT, zero, 1'b1);
    cfg_write(REG_REVERSE_OFFSET, offset, 1'b1);
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample(level_e lvl);
    int v;
    case (lvl)
      LVL_HIGH:     v = int'($urandom_range(3800, 4095));
      LVL_LOW:      v = int'($urandom_range(0, 300));
      LVL_FWD_EDGE: v = int'(board.zero) + int'(board.limit) + int'($urandom_range(0, 400)) - 200;
      LVL_REV_EDGE: v = int'(board.zero) - int'(board.limit) - int'(board.offset)
                        + int'($urandom_range(0, 400)) - 200;
      default:      v = int'($urandom_range(0, SAMPLE_MAX));
    endcase
    if (v < 0) v = 0;
    else if (v > SAMPLE_MAX) v = SAMPLE_MAX;
    return SAMPLE_W'(v);
  endfunction

  // mostly duties just off neutral, so steps reach the stop clamp
  function automatic logic [DRIVE_W-1:0] pick_drive();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 4) return DRIVE_W'($urandom_range(44, 49));
    if (pick < 8) return DRIVE_W'($urandom_range(51, 56));
    if (pick == 8) return DRIVE_W'(NEUTRAL);
    return DRIVE_W'($urandom_range(0, 127));
  endfunction

  task automatic run_random(input int unsigned count, input bit no_idle, input int hold_at,
                            input int pause_at);
    level_e      lvl;
    int unsigned seg_left;
    int unsigned burst_left;
    int unsigned gap;
    lvl = LVL_ANY;
    seg_left = 0;
    burst_left = $urandom_range(1, 24);
    for (int i = 0; i < count; i++) begin
      if (seg_left == 0) begin
        lvl = level_e'($urandom_range(0, 4));
        seg_left = $urandom_range(20, 60);
      end
      seg_left--;
      if (i == hold_at) hold_off_req = 1'b1;
      send_item(pick_sample(lvl), pick_drive());
      if (i == pause_at) begin
        sample_bus.valid <= 1'b0;
        wait_drained();
        burst_left = $urandom_range(1, 24);
      end else begin
        burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap = no_idle ? 0 : $urandom_range(0, 10);
          if (gap != 0) begin
            sample_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk_i);
          end
        end
      end
    end
    sample_bus.valid <= 1'b0;
  endtask

  initial begin : stimulus
    rst_ni                    <= 1'b0;
    sample_bus.valid          <= 1'b0;
    sample_bus.current_sample <= '0;
    sample_bus.drive_in       <= '0;
    psel                      <= 1'b0;
    penable                   <= 1'b0;
    pwrite                    <= 1'b0;
    paddr                     <= '0;
    pwdata                    <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // a write to the unused index must change nothing
    cfg_write(REG_SPARE_IDX, '1, 1'b0);
    repeat (SLACK_CYCLES) @(posedge clk_i);

    // field extremes while the window is still filling
    for (int i = 0; i < 24; i++) begin
      send_item(EDGE_SAMPLES[i % 8], EDGE_DRIVES[i % 12]);
    end
    run_random(176, 1'b0, -1, -1);

    // both thresholds at the middle, with a long result hold-off
    set_limits(0, 2048, 0);
    run_random(PHASE_ITEMS, 1'b0, 30, -1);

    set_limits(1861, 4095, 255);
    run_random(PHASE_ITEMS, 1'b1, -1, -1);

    // oversized write gets masked; reverse threshold goes negative
    set_limits('1, 0, 255);
    run_random(PHASE_ITEMS, 1'b0, -1, 70);

    set_limits(0, 0, 0);
    run_random(PHASE_ITEMS, 1'b0, -1, -1);

    set_limits(2047, 4095, 0);
    run_random(PHASE_ITEMS, 1'b0, -1, -1);

    set_limits($urandom_range(0, 2047), $urandom_range(0, 4095), $urandom_range(0, 255));
    run_random(PHASE_ITEMS, 1'b0, -1, -1);

    wait_drained();
    if (board.errors == 0) begin
      $display("motor_current_limit_stepper_test: done, clean");
    end else begin
      $display("motor_current_limit_stepper_test: done, errors");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+hdl
hdl/mcls_pkg.sv
hdl/mcls_stream_if.sv
hdl/mcls_cell.sv
hdl/mcls_divide.sv
hdl/motor_current_limit_stepper.sv
hdl/mcls_checker.sv
bench/motor_current_limit_stepper_test.sv
